// File: design/priority_lock_manager_unit_macros.svh
// assertion macros for the priority lock manager
`ifndef PRIORITY_LOCK_MANAGER_UNIT_MACROS_SVH
`define PRIORITY_LOCK_MANAGER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds on every clock edge out of reset
`define PLM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define PLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define PLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLM_ASSERT_ALWAYS(lbl, cond, msg)
`define PLM_ASSERT_IMP(lbl, ante, cons, msg)
`define PLM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/plm_pkg.sv
// shared types and status codes for the priority lock manager
`timescale 1ns / 1ps
package plm_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_FREED   = 3'd3,
    ST_HANDED  = 3'd4
  } status_t;

  // command codes
  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // per-cycle control broadcast to every queue cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

  localparam int IdPortW = 16;
  localparam int CountPortW = 5;

endpackage

// File: design/plm_cell.sv
// one slot of the sorted wait queue: holds an id and a valid bit
`timescale 1ns / 1ps
module plm_cell #(
  parameter int ID_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plm_pkg::cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0] new_id,
  input  logic                left_ge,
  input  logic [ID_WIDTH-1:0] left_id,
  input  logic                left_valid,
  input  logic [ID_WIDTH-1:0] right_id,
  input  logic                right_valid,
  output logic                ge,
  output logic [ID_WIDTH-1:0] id_q,
  output logic                valid_q
);
  import plm_pkg::*;

  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic                valid_r, valid_nxt;

  // new id goes at or before this slot: empty or holding an equal or higher id
  assign ge      = !valid_r || (id_r >= new_id);
  assign id_q    = id_r;
  assign valid_q = valid_r;

  // insert shifts toward the tail, pop shifts toward the head
  always_comb begin
    id_nxt    = id_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (left_ge) begin
        id_nxt    = left_id;
        valid_nxt = left_valid;
      end else if (ge) begin
        id_nxt    = new_id;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.pop) begin
      id_nxt    = right_id;
      valid_nxt = right_valid;
    end
  end

  // valid bit is control, id is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

// File: design/priority_lock_manager_unit.sv
// top level of the priority lock manager: lock state, sorted wait queue, result register
//
// Lock with a wait queue kept sorted by requester id, lowest first. Pulse start with
// in_cmd (acquire or release) and in_requester_id; busy is always low, so a new word
// may be issued every cycle. The queue is a row of QUEUE_DEPTH cells that each compare
// their id against the incoming one and shift together, which sets the rate at one
// word per cycle. The result appears on the out_ ports in the cycle after the word
// is taken, marked by out_valid for that one cycle; it cannot be held off, so capture
// it when out_valid is high. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "priority_lock_manager_unit_macros.svh"
module priority_lock_manager_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic [plm_pkg::IdPortW-1:0]      in_requester_id,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [plm_pkg::IdPortW-1:0]      out_owner_id,
  output logic                             out_lock_held,
  output logic [plm_pkg::IdPortW-1:0]      out_woken_id,
  output logic [plm_pkg::CountPortW-1:0]   out_waiting_count
);
  import plm_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic                in_accept;
  logic [ID_WIDTH+IdPortW-1:0] id_ext;
  logic [ID_WIDTH-1:0] req_id;
  cell_ctrl_t          ctrl;

  logic [QUEUE_DEPTH-1:0] ge_vec;
  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [ID_WIDTH-1:0]    id_arr [QUEUE_DEPTH];

  logic                held_r, held_nxt;
  logic [ID_WIDTH-1:0] holder_r, holder_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic [ID_WIDTH-1:0] woken;
  status_t             status;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [IdPortW-1:0]  out_owner_r;
  logic                out_held_r;
  logic [IdPortW-1:0]  out_woken_r;
  logic [CountPortW-1:0] out_count_r;

  logic [ID_WIDTH+IdPortW-1:0] owner_ext, woken_ext;
  logic [CntW+CountPortW-1:0]  count_ext;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // requester id reduced or widened to the stored id width
  assign id_ext = {{ID_WIDTH{1'b0}}, in_requester_id};
  assign req_id = id_ext[ID_WIDTH-1:0];

  // lock decision and queue control
  always_comb begin
    held_nxt    = held_r;
    holder_nxt  = holder_r;
    count_nxt   = count_r;
    woken       = '0;
    status      = ST_GRANTED;
    ctrl.insert = 1'b0;
    ctrl.pop    = 1'b0;
    if (in_cmd == CMD_ACQUIRE) begin
      if (!held_r) begin
        held_nxt   = 1'b1;
        holder_nxt = req_id;
        status     = ST_GRANTED;
      end else if (!valid_vec[QUEUE_DEPTH-1]) begin
        ctrl.insert = in_accept;
        count_nxt   = count_r + CntW'(1);
        status      = ST_QUEUED;
      end else begin
        status = ST_DROPPED;
      end
    end else begin
      if (valid_vec[0]) begin
        ctrl.pop   = in_accept;
        woken      = id_arr[0];
        held_nxt   = 1'b1;
        holder_nxt = id_arr[0];
        count_nxt  = count_r - CntW'(1);
        status     = ST_HANDED;
      end else begin
        held_nxt   = 1'b0;
        holder_nxt = '0;
        status     = ST_FREED;
      end
    end
  end

  // chain of queue cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                l_ge;
    logic [ID_WIDTH-1:0] l_id;
    logic                l_valid;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_valid;

    if (i == 0) begin : g_head
      assign l_ge    = 1'b0;
      assign l_id    = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_ge    = ge_vec[i-1];
      assign l_id    = id_arr[i-1];
      assign l_valid = valid_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id    = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_id    = id_arr[i+1];
      assign r_valid = valid_vec[i+1];
    end

    plm_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_id     (req_id),
      .left_ge    (l_ge),
      .left_id    (l_id),
      .left_valid (l_valid),
      .right_id   (r_id),
      .right_valid(r_valid),
      .ge         (ge_vec[i]),
      .id_q       (id_arr[i]),
      .valid_q    (valid_vec[i])
    );
  end

  // result fields sized to the port widths
  assign owner_ext = {{IdPortW{1'b0}}, (held_nxt ? holder_nxt : {ID_WIDTH{1'b0}})};
  assign woken_ext = {{IdPortW{1'b0}}, woken};
  assign count_ext = {{CountPortW{1'b0}}, count_nxt};

  // lock state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      holder_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_accept;
      if (in_accept) begin
        held_r   <= held_nxt;
        holder_r <= holder_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status_r <= status;
      out_owner_r  <= owner_ext[IdPortW-1:0];
      out_held_r   <= held_nxt;
      out_woken_r  <= woken_ext[IdPortW-1:0];
      out_count_r  <= count_ext[CountPortW-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_owner_id      = out_owner_r;
  assign out_lock_held     = out_held_r;
  assign out_woken_id      = out_woken_r;
  assign out_waiting_count = out_count_r;

  // checks
  `PLM_ASSERT_ALWAYS(a_count_match, count_r == CntW'($countones(valid_vec)), "count mismatch")
  `PLM_ASSERT_ALWAYS(a_valid_prefix, ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0, "queue has a hole")
  `PLM_ASSERT_IMP(a_queue_needs_holder, valid_vec[0], held_r, "waiters on a free lock")
  `PLM_ASSERT_NEXT(a_result_strobe, in_accept, out_valid, "missing result")

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the priority lock manager
`timescale 1ns / 1ps
module tb_top;
  import plm_pkg::*;

  localparam int WaitDepth  = 16;    // queue depth of the default build
  localparam int RandItems  = 1550;
  localparam int TailItems  = 200;   // last words go in back to back
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 8;

  // one expected result word
  typedef struct packed {
    status_t                status;
    logic [IdPortW-1:0]     owner;
    logic                   held;
    logic [IdPortW-1:0]     woken;
    logic [CountPortW-1:0]  count;
  } lock_result_t;

  // one pending request word
  typedef struct packed {
    cmd_t               cmd;
    logic [IdPortW-1:0] id;
  } lock_req_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_cmd;
  logic [IdPortW-1:0]     in_requester_id;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [IdPortW-1:0]     out_owner_id;
  logic                   out_lock_held;
  logic [IdPortW-1:0]     out_woken_id;
  logic [CountPortW-1:0]  out_waiting_count;

  lock_req_t          pending_reqs[$];
  lock_result_t       expected_results[$];
  int unsigned        fail_cnt;
  int unsigned        gap_left;
  int unsigned        stall_cycles;

  // predictor state: lock flag, current holder, sorted waiter ids
  logic               lock_taken;
  logic [IdPortW-1:0] lock_owner;
  logic [IdPortW-1:0] waiter_ids[$];

  priority_lock_manager_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_requester_id   (in_requester_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_owner_id      (out_owner_id),
    .out_lock_held     (out_lock_held),
    .out_woken_id      (out_woken_id),
    .out_waiting_count (out_waiting_count)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one request to the lock and return the word it should produce
  function automatic lock_result_t lock_step(cmd_t cmd, logic [IdPortW-1:0] id);
    lock_result_t res;
    int           pos;
    res.woken = '0;
    if (cmd == CMD_ACQUIRE) begin
      if (!lock_taken) begin
        lock_taken = 1'b1;
        lock_owner = id;
        res.status = ST_GRANTED;
      end else if (waiter_ids.size() < WaitDepth) begin
        // new waiter goes ahead of any equal or higher id
        pos = 0;
        while (pos < waiter_ids.size() && waiter_ids[pos] < id) pos++;
        waiter_ids.insert(pos, id);
        res.status = ST_QUEUED;
      end else begin
        res.status = ST_DROPPED;
      end
    end else begin
      if (waiter_ids.size() != 0) begin
        res.woken  = waiter_ids.pop_front();
        lock_taken = 1'b1;
        lock_owner = res.woken;
        res.status = ST_HANDED;
      end else begin
        lock_taken = 1'b0;
        lock_owner = '0;
        res.status = ST_FREED;
      end
    end
    res.owner = lock_taken ? lock_owner : '0;
    res.held  = lock_taken;
    res.count = CountPortW'(waiter_ids.size());
    return res;
  endfunction

  function automatic logic [IdPortW-1:0] rand_id();
    case ($urandom_range(0, 9))
      0, 1, 2: rand_id = IdPortW'($urandom_range(0, 7));   // crowded range, many equal ids
      3:       rand_id = '0;
      4:       rand_id = '1;
      5:       rand_id = IdPortW'(1 << $urandom_range(0, IdPortW - 1));
      default: rand_id = IdPortW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_req(cmd_t cmd, logic [IdPortW-1:0] id);
    lock_req_t r;
    r.cmd = cmd;
    r.id  = id;
    pending_reqs.push_back(r);
  endtask

  task automatic note_error(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (fail_cnt < 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    fail_cnt++;
  endtask

  // driver: issue pending words with random idle bursts
  always @(posedge clk) begin : drive_proc
    lock_req_t req;
    logic      take;
    if (!rst_n) begin
      start           <= 1'b0;
      in_cmd          <= CMD_ACQUIRE;
      in_requester_id <= '0;
      gap_left        <= 0;
    end else begin
      take = start && !busy;
      if (take)
        expected_results.push_back(lock_step(cmd_t'(in_cmd), in_requester_id));
      if (start && !take) begin
        // word still waiting for the block, keep it on the ports
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_reqs.size() > TailItems && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 10);
        start    <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req              = pending_reqs.pop_front();
        start           <= 1'b1;
        in_cmd          <= req.cmd;
        in_requester_id <= req.id;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : check_proc
    lock_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        note_error("unexpected word status", '0, 32'(out_status));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status)
          note_error("status", 32'(exp_r.status), 32'(out_status));
        if (out_owner_id !== exp_r.owner)
          note_error("owner_id", 32'(exp_r.owner), 32'(out_owner_id));
        if (out_lock_held !== exp_r.held)
          note_error("lock_held", 32'(exp_r.held), 32'(out_lock_held));
        if (out_woken_id !== exp_r.woken)
          note_error("woken_id", 32'(exp_r.woken), 32'(out_woken_id));
        if (out_waiting_count !== exp_r.count)
          note_error("waiting_count", 32'(exp_r.count), 32'(out_waiting_count));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    int unsigned n_rand;
    int unsigned acq_pct;
    int unsigned run_len;
    rst_n      = 1'b0;
    fail_cnt   = 0;
    lock_taken = 1'b0;
    lock_owner = '0;

    // directed: release while free, id zero holding, holder asking again
    add_req(CMD_RELEASE, 16'h1234);
    add_req(CMD_ACQUIRE, 16'h0000);
    add_req(CMD_ACQUIRE, 16'h0000);
    // fill the queue with extremes and equal ids, then overflow it
    add_req(CMD_ACQUIRE, 16'hFFFF);
    add_req(CMD_ACQUIRE, 16'h8000);
    add_req(CMD_ACQUIRE, 16'h8000);
    add_req(CMD_ACQUIRE, 16'h0001);
    add_req(CMD_ACQUIRE, 16'h5555);
    add_req(CMD_ACQUIRE, 16'hAAAA);
    add_req(CMD_ACQUIRE, 16'h0000);
    add_req(CMD_ACQUIRE, 16'h7FFF);
    add_req(CMD_ACQUIRE, 16'hFFFE);
    add_req(CMD_ACQUIRE, 16'h0002);
    add_req(CMD_ACQUIRE, 16'h0100);
    add_req(CMD_ACQUIRE, 16'h00FF);
    add_req(CMD_ACQUIRE, 16'h1000);
    add_req(CMD_ACQUIRE, 16'hFFFF);
    add_req(CMD_ACQUIRE, 16'h0003);
    add_req(CMD_ACQUIRE, 16'h0000);
    // hand-overs, releasing id not checked against the holder
    add_req(CMD_RELEASE, 16'hFFFF);
    add_req(CMD_RELEASE, 16'h0000);
    add_req(CMD_ACQUIRE, 16'h0004);
    add_req(CMD_RELEASE, 16'h4321);

    // random: runs that lean toward filling, churning or draining the queue
    n_rand = 0;
    while (n_rand < RandItems) begin
      case ($urandom_range(0, 3))
        0:       acq_pct = 90;
        1:       acq_pct = 60;
        2:       acq_pct = 45;
        default: acq_pct = 20;
      endcase
      run_len = $urandom_range(10, 60);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < acq_pct) add_req(CMD_ACQUIRE, rand_id());
        else add_req(CMD_RELEASE, rand_id());
      end
      n_rand += run_len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
